FILE: rtl/sec_pkg.sv
// shared types and constants for the sorted event cursor
// no dependencies; imported by every module of the block
`default_nettype none
package sec_pkg;

   // field widths fixed by the request and response formats
   localparam int TIME_W         = 16;
   localparam int LEN_W          = TIME_W + 1;
   localparam int INDEX_OUT_W    = 9;
   localparam int MAX_EVENTS_DEF = 256;
   localparam logic [TIME_W-1:0] LOOP_LEN_RESET = 16'd256;

   // request kinds
   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_SEEK   = 2'd2,
      KIND_MOVE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [TIME_W-1:0]         tick_time;
      logic signed [TIME_W-1:0]  step_amount;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]      cursor_time;
      logic [INDEX_OUT_W-1:0] event_index;
      logic                   wrapped;
      logic                   status;
   } rsp_type;

   // controls from the sequencer to the ring of timestamp cells
   typedef struct packed {
      logic              rot_fwd;
      logic              rot_bwd;
      logic              wr_en;
      logic [TIME_W-1:0] wr_data;
   } ring_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/sec_cell.sv
// one timestamp cell of the rotating ring
// depends on sec_pkg for the ring control struct
`default_nettype none
module sec_cell (
   input  wire                  clock,
   input  sec_pkg::ring_ctl_type ctl,
   input  wire                  wr_sel,
   input  wire  [15:0]          from_next,
   input  wire  [15:0]          from_prev,
   output logic [15:0]          value
);
   import sec_pkg::*;

   logic [TIME_W-1:0] value_ff, value_in;

   // write at the head cell, otherwise take the neighbor's entry on rotation
   always_comb begin
      value_in = value_ff;
      if (wr_sel && ctl.wr_en) begin
         value_in = ctl.wr_data;
      end else if (ctl.rot_fwd) begin
         value_in = from_next;
      end else if (ctl.rot_bwd) begin
         value_in = from_prev;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

FILE: rtl/sec_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
// depends on sec_pkg for widths
`default_nettype none
module sec_mod (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [16:0] dividend,
   input  wire  [16:0] divisor,
   output logic        done,
   output logic [16:0] remainder
);
   import sec_pkg::*;

   localparam int CNT_W = $clog2(LEN_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  dvd_ff, dvd_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W:0]    trial;
   logic [LEN_W:0]    diff;

   // restoring step: shift in next bit, subtract when it fits
   assign trial = {rem_ff, dvd_ff[LEN_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(LEN_W);
         dvd_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[LEN_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[LEN_W-1:0];
         end else begin
            rem_in = trial[LEN_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/sec_ctrl.sv
// request sequencer: cursor state, search and stepping over the cell ring
// depends on sec_pkg; drives sec_mod and the ring of sec_cell
`default_nettype none
module sec_ctrl #(
   parameter int MAX_EVENTS = sec_pkg::MAX_EVENTS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  sec_pkg::req_type      req_data,
   output logic                  rsp_valid,
   output sec_pkg::rsp_type      rsp_data,
   input  wire                   csr_write_en,
   input  wire  [15:0]           csr_write_data,
   input  wire  [15:0]           head_time,
   output sec_pkg::ring_ctl_type ring_ctl,
   output logic                  div_start,
   output logic [16:0]           div_dividend,
   output logic [16:0]           div_divisor,
   input  wire                   div_done,
   input  wire  [16:0]           div_rem
);
   import sec_pkg::*;

   localparam int CW = $clog2(MAX_EVENTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_SCAN} state_type;
   typedef enum logic [1:0] {MODE_APPEND, MODE_SEEK, MODE_FWD, MODE_BWD} mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     index_ff, index_in;
   logic [CW-1:0]     head_ff, head_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hp_ff, hp_in;
   logic [TIME_W-1:0] pos_ff, pos_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [TIME_W-1:0] loop_len_ff, loop_len_in;
   logic              wrapped_ff, wrapped_in;
   logic              status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  fwd_sum;
   logic [LEN_W:0]    bwd_sum;
   logic [LEN_W:0]    bwd_mag;
   logic [LEN_W-1:0]  wrap_up;
   logic [CW:0]       mid_sum;
   logic [CW-1:0]     mid;
   logic [CW-1:0]     target;
   logic              done;

   // zero length register means a full 16-bit loop
   assign len = (loop_len_ff == '0) ? {1'b1, {TIME_W{1'b0}}} : {1'b0, loop_len_ff};

   // candidate positions for a move request
   assign fwd_sum = {1'b0, pos_ff} + {2'b00, req_data.step_amount[TIME_W-2:0]};
   assign bwd_sum = {2'b00, pos_ff}
                  + {{2{req_data.step_amount[TIME_W-1]}}, req_data.step_amount};
   assign bwd_mag = '0 - bwd_sum;
   assign wrap_up = len - div_rem;

   // binary search midpoint over [lo, hp)
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hp_ff} - (CW+1)'(1);
   assign mid     = mid_sum[CW:1];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      head_in      = head_ff;
      lo_in        = lo_ff;
      hp_in        = hp_ff;
      pos_in       = pos_ff;
      tick_in      = tick_ff;
      loop_len_in  = loop_len_ff;
      wrapped_in   = wrapped_ff;
      status_in    = status_ff;
      done         = 1'b0;
      target       = index_ff;
      div_start    = 1'b0;
      div_dividend = {1'b0, req_data.tick_time};
      ring_ctl     = '0;
      ring_ctl.wr_data = tick_ff;

      if (csr_write_en) begin
         loop_len_in = csr_write_data;
      end

      unique case (state_ff)
         // take a new request
         ST_IDLE: begin
            if (start) begin
               wrapped_in = 1'b0;
               status_in  = 1'b0;
               tick_in    = req_data.tick_time;
               unique case (req_data.kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                     index_in = '0;
                     done     = 1'b1;
                  end
                  KIND_APPEND: begin
                     if (count_ff == CW'(MAX_EVENTS)) begin
                        status_in = 1'b1;
                        done      = 1'b1;
                     end else begin
                        mode_in  = MODE_APPEND;
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_SEEK: begin
                     wrapped_in   = ({1'b0, req_data.tick_time} >= len);
                     div_start    = 1'b1;
                     div_dividend = {1'b0, req_data.tick_time};
                     mode_in      = MODE_SEEK;
                     state_in     = ST_MOD;
                  end
                  KIND_MOVE: begin
                     if (req_data.step_amount == '0) begin
                        done = 1'b1;
                     end else if (!req_data.step_amount[TIME_W-1]) begin
                        mode_in = MODE_FWD;
                        if (fwd_sum >= len) begin
                           wrapped_in   = 1'b1;
                           div_start    = 1'b1;
                           div_dividend = fwd_sum;
                           state_in     = ST_MOD;
                        end else begin
                           pos_in   = fwd_sum[TIME_W-1:0];
                           state_in = ST_SCAN;
                        end
                     end else begin
                        mode_in = MODE_BWD;
                        if (bwd_sum[LEN_W]) begin
                           wrapped_in   = 1'b1;
                           div_start    = 1'b1;
                           div_dividend = bwd_mag[LEN_W-1:0];
                           state_in     = ST_MOD;
                        end else begin
                           pos_in   = bwd_sum[TIME_W-1:0];
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         // wait for the remainder, then set up the index pass
         ST_MOD: begin
            if (div_done) begin
               state_in = ST_SCAN;
               unique case (mode_ff)
                  MODE_SEEK: begin
                     pos_in = div_rem[TIME_W-1:0];
                     lo_in  = '0;
                     hp_in  = count_ff;
                     if (div_rem == '0 || count_ff == '0) begin
                        index_in = '0;
                        state_in = ST_IDLE;
                        done     = 1'b1;
                     end
                  end
                  MODE_FWD: begin
                     pos_in   = div_rem[TIME_W-1:0];
                     index_in = '0;
                  end
                  MODE_BWD: begin
                     pos_in   = (div_rem == '0) ? '0 : wrap_up[TIME_W-1:0];
                     index_in = count_ff;
                  end
                  default: begin
                     state_in = ST_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end
         end

         // rotate the ring to the wanted entry and decide on it
         ST_SCAN: begin
            unique case (mode_ff)
               MODE_APPEND: begin
                  target = count_ff;
                  if (head_ff == target) begin
                     ring_ctl.wr_en = 1'b1;
                     count_in       = count_ff + CW'(1);
                     done           = 1'b1;
                  end
               end
               MODE_FWD: begin
                  target = index_ff;
                  if (index_ff >= count_ff) begin
                     done = 1'b1;
                  end else if (head_ff == target) begin
                     if (head_time < pos_ff) begin
                        index_in = index_ff + CW'(1);
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               MODE_BWD: begin
                  target = index_ff - CW'(1);
                  if (index_ff == '0) begin
                     done = 1'b1;
                  end else if (head_ff == target) begin
                     if (head_time >= pos_ff) begin
                        index_in = target;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end
               MODE_SEEK: begin
                  target = mid;
                  if (lo_ff >= hp_ff) begin
                     index_in = lo_ff;
                     done     = 1'b1;
                  end else if (head_ff == target) begin
                     if (head_time < pos_ff) begin
                        lo_in = mid + CW'(1);
                     end else if (head_time > pos_ff) begin
                        hp_in = mid;
                     end else begin
                        index_in = mid;
                        done     = 1'b1;
                     end
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            // step the ring one cell toward the target entry
            if (!done && head_ff != target) begin
               if (target > head_ff) begin
                  ring_ctl.rot_fwd = 1'b1;
                  head_in          = head_ff + CW'(1);
               end else begin
                  ring_ctl.rot_bwd = 1'b1;
                  head_in          = head_ff - CW'(1);
               end
            end
            if (done) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // response for the finishing request
      rsp_valid_in       = done;
      rsp_in.cursor_time = pos_in;
      rsp_in.event_index = INDEX_OUT_W'(index_in);
      rsp_in.wrapped     = wrapped_in;
      rsp_in.status      = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_APPEND;
         count_ff     <= '0;
         index_ff     <= '0;
         head_ff      <= '0;
         pos_ff       <= '0;
         loop_len_ff  <= LOOP_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         head_ff      <= head_in;
         pos_ff       <= pos_in;
         loop_len_ff  <= loop_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff      <= lo_in;
      hp_ff      <= hp_in;
      tick_ff    <= tick_in;
      wrapped_ff <= wrapped_in;
      status_ff  <= status_in;
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign div_divisor = len;

endmodule
`default_nettype wire

FILE: rtl/sorted_event_cursor.sv
// sorted event cursor: timestamp table in a rotating ring of cells, loop cursor
// clear, refused append and zero move answer straight from idle; append rotates the ring
// to the table end to write; seek takes a remainder, then a binary search rotates to each probe
// move walks the table an event at a time, after a remainder and an index reset when it wraps
// one request at a time, the next taken in the result cycle; results cannot be held off
// synchronous reset empties the table, zeroes cursor, index and ring head, loop length 256
`default_nettype none
module sorted_event_cursor #(
   parameter int MAX_EVENTS = sec_pkg::MAX_EVENTS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  sec_pkg::req_type  req_data,
   output logic              rsp_valid,
   output sec_pkg::rsp_type  rsp_data,
   input  wire               csr_write_en,
   input  wire  [15:0]       csr_write_data
);
   import sec_pkg::*;

   ring_ctl_type       ring_ctl;
   logic [TIME_W-1:0]  cell_val [MAX_EVENTS];
   logic               div_start;
   logic [LEN_W-1:0]   div_dividend;
   logic [LEN_W-1:0]   div_divisor;
   logic               div_done;
   logic [LEN_W-1:0]   div_rem;

   // sequencer
   sec_ctrl #(
      .MAX_EVENTS(MAX_EVENTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .head_time      (cell_val[0]),
      .ring_ctl       (ring_ctl),
      .div_start      (div_start),
      .div_dividend   (div_dividend),
      .div_divisor    (div_divisor),
      .div_done       (div_done),
      .div_rem        (div_rem)
   );

   // remainder unit for seek and wrapping moves
   sec_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // ring of timestamp cells, cell 0 is the head read by the sequencer
   for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_cell
      sec_cell u_cell (
         .clock     (clock),
         .ctl       (ring_ctl),
         .wr_sel    (1'(i == 0)),
         .from_next (cell_val[(i + 1) % MAX_EVENTS]),
         .from_prev (cell_val[(i + MAX_EVENTS - 1) % MAX_EVENTS]),
         .value     (cell_val[i])
      );
   end

endmodule
`default_nettype wire

FILE: rtl/sec_checker.sv
// port-level checks for the sorted event cursor, bound to the top level
// depends on sec_pkg and sorted_event_cursor
`default_nettype none
module sec_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input sec_pkg::req_type req_data,
   input wire              rsp_valid,
   input sec_pkg::rsp_type rsp_data
);
   import sec_pkg::*;

   // a response marks the end of the request, so the block is free again
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // every accepted request either keeps working or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor answered");

   // a clear answers next cycle with index zero and no flags
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_CLEAR) |=>
         (rsp_valid && rsp_data.event_index == '0 && !rsp_data.wrapped
          && !rsp_data.status))
      else $error("clear response wrong");

   // a refused append never reports a wrap
   a_status_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> !rsp_data.wrapped)
      else $error("refused append reports wrap");

endmodule

bind sorted_event_cursor sec_checker u_sec_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: dv/tb_sorted_event_cursor.sv
// self-checking testbench for sorted_event_cursor: directed and random requests,
// loop length changes between phases, responses checked against an in-bench model
// depends on rtl/sec_pkg.sv and rtl/sorted_event_cursor.sv
`timescale 1ns / 100ps

module tb_sorted_event_cursor;
   import sec_pkg::*;

   localparam int          TABLE_DEPTH = MAX_EVENTS_DEF;
   localparam int unsigned CYCLE_LIMIT = 15_000_000;
   localparam int          DRAIN_LIMIT = 50_000;
   localparam int          SETTLE      = 8;
   localparam int          CHUNK_ITEMS = 26;

   // cursor model plus the queue of responses it has predicted
   class cursor_scoreboard;
      logic [TIME_W-1:0] stamps [TABLE_DEPTH];
      int unsigned       count;
      int unsigned       pos;
      int unsigned       idx;
      logic [TIME_W-1:0] loop_len;
      rsp_type           pending_rsp [$];
      int                errors;
      int                n_checked;
      int                n_wraps;
      int                n_refused;

      function new();
         count     = 0;
         pos       = 0;
         idx       = 0;
         loop_len  = LOOP_LEN_RESET;
         errors    = 0;
         n_checked = 0;
         n_wraps   = 0;
         n_refused = 0;
      endfunction

      function void set_loop_length(logic [TIME_W-1:0] v);
         loop_len = v;
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function int unsigned span();
         return (loop_len == 0) ? 32'd65536 : int'(loop_len);
      endfunction

      // binary search; an exact hit stops at whichever equal entry it probes
      function int unsigned locate();
         int lo;
         int hi;
         int mid;
         if (pos == 0 || count == 0) return 0;
         lo = 0;
         hi = int'(count) - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (stamps[mid] < pos) lo = mid + 1;
            else if (stamps[mid] > pos) hi = mid - 1;
            else return mid;
         end
         return lo;
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned len;
         int unsigned p;
         int          q;
         int          amt;
         logic        wrap;
         logic        refused;
         len     = span();
         amt     = int'($signed(r.step_amount));
         wrap    = 1'b0;
         refused = 1'b0;
         case (r.kind)
            KIND_CLEAR: begin
               count = 0;
               idx   = 0;
            end
            KIND_APPEND: begin
               if (count >= TABLE_DEPTH) begin
                  refused = 1'b1;
               end else begin
                  stamps[count] = r.tick_time;
                  count++;
               end
            end
            KIND_SEEK: begin
               wrap = (r.tick_time >= len);
               pos  = r.tick_time % len;
               idx  = locate();
            end
            default: begin
               // forward move wraps by remainder, then walks up the table
               if (amt > 0) begin
                  p = pos + amt;
                  if (p >= len) begin
                     p    = p % len;
                     idx  = 0;
                     wrap = 1'b1;
                  end
                  pos = p;
                  while (idx < count && stamps[idx] < pos) idx++;
               end else if (amt < 0) begin
                  // backward move only corrects a negative sum
                  q = int'(pos) + amt;
                  if (q < 0) begin
                     while (q < 0) q += int'(len);
                     idx  = count;
                     wrap = 1'b1;
                  end
                  pos = q;
                  while (idx > 0 && stamps[idx-1] >= pos) idx--;
               end
            end
         endcase
         e.cursor_time = pos[TIME_W-1:0];
         e.event_index = idx[INDEX_OUT_W-1:0];
         e.wrapped     = wrap;
         e.status      = refused;
         pending_rsp.push_back(e);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (got.wrapped) n_wraps++;
            if (got.status) n_refused++;
            if (got.cursor_time !== want.cursor_time)
               report_mismatch($sformatf("response %0d cursor_time got %0d want %0d",
                  n_checked, got.cursor_time, want.cursor_time));
            if (got.event_index !== want.event_index)
               report_mismatch($sformatf("response %0d event_index got %0d want %0d",
                  n_checked, got.event_index, want.event_index));
            if (got.wrapped !== want.wrapped)
               report_mismatch($sformatf("response %0d wrapped got %b want %b",
                  n_checked, got.wrapped, want.wrapped));
            if (got.status !== want.status)
               report_mismatch($sformatf("response %0d status got %b want %b",
                  n_checked, got.status, want.status));
         end
      endtask
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              busy;
   req_type           req_data       = '0;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [15:0]       csr_write_data = '0;

   cursor_scoreboard  board;
   int unsigned       cycle_count    = 0;
   int                sent           = 0;
   int                idle_pct       = 0;
   int                n_settings     = 0;
   logic [TIME_W-1:0] episode_stamps [$];

   sorted_event_cursor dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // monitor: responses first, then a request taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) board.check_response(rsp_data);
         if (start && busy === 1'b0) board.note_request(req_data);
      end
   end

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   // random sender gap, then hold the request until it is taken
   task automatic issue(kind_type k, logic [15:0] t, logic [15:0] a);
      req_type r;
      r.kind        = k;
      r.tick_time   = t;
      r.step_amount = a;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   // one edge first so the request taken at the last edge is already noted
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_loop_length(logic [15:0] v);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      board.set_loop_length(v);
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   // one seek or move, aimed at stored times and at the loop end
   task automatic issue_cursor(int unsigned len);
      int          amt;
      int unsigned sel;
      logic [15:0] t;
      if ($urandom_range(99) < 40) begin
         sel = $urandom_range(2);
         if (sel == 0 && episode_stamps.size() > 0)
            t = episode_stamps[$urandom_range(0, episode_stamps.size() - 1)];
         else if (sel == 2)
            t = rnd16();
         else
            t = 16'($urandom_range(0, len - 1));
         issue(KIND_SEEK, t, rnd16());
      end else begin
         sel = $urandom_range(9);
         if (sel == 0)
            amt = 0;
         else if (sel <= 4)
            amt = $urandom_range(1, len / 8 + 1);
         else if (sel <= 7)
            amt = -int'($urandom_range(1, len / 8 + 1));
         else if (sel == 8)
            amt = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(len / 2, len + len / 2));
         else
            amt = int'($signed(rnd16()));
         if (amt > 32767) amt = 32767;
         if (amt < -32768) amt = -32768;
         issue(KIND_MOVE, rnd16(), amt[15:0]);
      end
   endtask

   // mostly a clear, a short ascending table and cursor traffic; some noise
   task automatic run_episode(int unsigned len);
      int          n;
      int unsigned t;
      if ($urandom_range(99) < 80) begin
         episode_stamps.delete();
         issue(KIND_CLEAR, rnd16(), rnd16());
         n = $urandom_range(0, 20);
         t = $urandom_range(0, len / 4);
         for (int i = 0; i < n; i++) begin
            if (t > 65535) t = 65535;
            episode_stamps.push_back(t[15:0]);
            issue(KIND_APPEND, t[15:0], rnd16());
            t += $urandom_range(0, len / (n + 1));
         end
         repeat ($urandom_range(3, 12)) issue_cursor(len);
      end else begin
         repeat ($urandom_range(1, 6))
            issue(kind_type'($urandom_range(0, 3)), rnd16(), rnd16());
      end
   endtask

   // full table, refused appends, then searches and walks over all of it
   task automatic fill_table(int unsigned len);
      int unsigned t;
      episode_stamps.delete();
      issue(KIND_CLEAR, rnd16(), rnd16());
      t = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t += $urandom_range(0, 255);
         if (t > 65535) t = 65535;
         episode_stamps.push_back(t[15:0]);
         issue(KIND_APPEND, t[15:0], rnd16());
      end
      repeat (3) issue(KIND_APPEND, rnd16(), rnd16());
      repeat (3) issue_cursor(len);
      issue(KIND_SEEK, episode_stamps[TABLE_DEPTH-1], 16'h0);
      issue(KIND_MOVE, 16'h0, 16'sh7fff);
      issue(KIND_MOVE, 16'h0, 16'sh8000);
      issue(KIND_CLEAR, rnd16(), rnd16());
   endtask

   initial begin
      int unsigned lens [8];
      int          base;
      int          waited;
      board = new();
      lens  = '{32'd0, 32'd1, 32'd65535, 32'd100, 32'd256, 32'd0, 32'd3, 32'd1000};
      lens[5] = $urandom_range(2, 65534);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, duplicates, exact and missed seeks, both wraps
      idle_pct = 35;
      issue(KIND_MOVE, 16'h0, 16'sh0);
      issue(KIND_SEEK, 16'h0, 16'h0);
      issue(KIND_APPEND, 16'd10, 16'h0);
      issue(KIND_APPEND, 16'd20, 16'h0);
      issue(KIND_APPEND, 16'd20, 16'h0);
      issue(KIND_APPEND, 16'd20, 16'h0);
      issue(KIND_APPEND, 16'd40, 16'h0);
      issue(KIND_SEEK, 16'd20, 16'h0);
      issue(KIND_SEEK, 16'd25, 16'h0);
      issue(KIND_SEEK, 16'd300, 16'h0);
      issue(KIND_SEEK, 16'd40, 16'h0);
      issue(KIND_MOVE, 16'h0, 16'sd5);
      issue(KIND_MOVE, 16'h0, 16'sd300);
      issue(KIND_MOVE, 16'h0, -16'sd1000);
      issue(KIND_MOVE, 16'hffff, 16'sh0);
      issue(KIND_MOVE, 16'h0, 16'sh8000);
      issue(KIND_MOVE, 16'h0, 16'sh7fff);
      issue(KIND_SEEK, 16'd255, 16'h0);
      // clear keeps the position
      issue(KIND_CLEAR, 16'hffff, 16'hffff);
      issue(KIND_SEEK, 16'hffff, 16'h7fff);
      // out-of-order appends are taken as they come
      issue(KIND_APPEND, 16'hffff, 16'h0);
      issue(KIND_APPEND, 16'h0, 16'h0);
      issue(KIND_MOVE, 16'h0, -16'sd1);
      issue(KIND_SEEK, 16'd200, 16'h0);
      // shrink the loop under the position
      write_loop_length(16'd40);
      issue(KIND_MOVE, 16'h0, -16'sd5);
      issue(KIND_MOVE, 16'h0, 16'sd1);
      // zero length acts as the full 16-bit loop
      write_loop_length(16'd0);
      issue(KIND_SEEK, 16'hffff, 16'h0);
      issue(KIND_MOVE, 16'h0, 16'sd1);

      // random phases over several loop lengths and sender idle rates
      for (int c = 0; c < 8; c++) begin
         idle_pct = (c < 3) ? 35 : (c < 6) ? 63 : 0;
         write_loop_length(lens[c][15:0]);
         if (c == 0) fill_table(board.span());
         base = sent;
         while (sent - base < CHUNK_ITEMS) begin
            run_episode(board.span());
            // occasionally let everything drain before going on
            if ($urandom_range(9) == 0) wait_drained();
         end
      end

      // drain and watch for stray responses
      start  <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (board.pending() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (board.pending() > 0)
         board.report_mismatch($sformatf("%0d responses never arrived", board.pending()));

      $display("run: %0d requests, %0d responses checked, %0d loop length settings",
         sent, board.n_checked, n_settings);
      $display("     %0d wrapped responses, %0d refused appends, %0d mismatches",
         board.n_wraps, board.n_refused, board.errors);
      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
